// ===== hdl/lpfm_pkg.sv =====
// lpfm_pkg: types and constants for the LRU page frame manager.
// No dependencies.
`timescale 1ns / 1ps
package lpfm_pkg;

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_SECTOR = 2'd2;
  localparam logic [1:0] CMD_ERROR  = 2'd3;

  localparam logic [1:0] LOAD_NONE = 2'd0;
  localparam logic [1:0] LOAD_FILL = 2'd1;
  localparam logic [1:0] LOAD_SWAP = 2'd2;
  localparam logic [1:0] LOAD_SRC  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [19:0] address;
    logic [31:0] img_base;
    logic [31:0] img_offset;
    logic        has_source;
    logic        source_is_image;
    logic        exec_fetch;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        hit;
    logic [3:0]  frame;
    logic        write_back;
    logic [10:0] evicted_page;
    logic [10:0] write_slot;
    logic [1:0]  load_kind;
    logic [10:0] load_slot;
    logic [31:0] source_offset;
    logic [9:0]  load_bytes;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take;    // latch input item, start page read
    logic scan;    // compare one frame age
    logic owner;   // launch owner read
    logic commit;  // update tables, build result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic halt;    // halted or error command
    logic hit;
    logic scan_done;
    logic clr_done;
  } dp_sts_t;

endpackage

// ===== hdl/lpfm_stream_if.sv =====
// lpfm_stream_if: valid/ready channel carrying one payload item.
// No dependencies.
`timescale 1ns / 1ps
interface lpfm_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/lpfm_ctrl.sv =====
// lpfm_ctrl: sequencer for lookup, victim scan and table commit.
// Depends on lpfm_pkg.
`timescale 1ns / 1ps
module lpfm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lpfm_pkg::dp_cmd_t  cmd,
  input  lpfm_pkg::dp_sts_t  sts
);
  typedef enum logic [6:0] {
    S_CLR    = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_LOOK   = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_OWNER  = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_CLR: begin
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.halt || sts.hit) begin
          cmd.commit = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_OWNER;
      end
      S_OWNER: begin
        cmd.owner = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("accept while result pending");
endmodule

// ===== hdl/lpfm_dp.sv =====
// lpfm_dp: page table memories, frame age/owner registers, result build.
// Depends on lpfm_pkg.
`timescale 1ns / 1ps
module lpfm_dp #(
  parameter int PAGE_SHIFT = 9,
  parameter int NUM_PAGES  = 2048,
  parameter int NUM_FRAMES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lpfm_pkg::in_item_t   in_item,
  input  logic [31:0]          image_size,
  input  lpfm_pkg::dp_cmd_t    cmd,
  output lpfm_pkg::dp_sts_t    sts,
  output lpfm_pkg::out_item_t  res
);
  localparam int PW = $clog2(NUM_PAGES);
  localparam int FW = $clog2(NUM_FRAMES);
  localparam logic [32:0] PSIZE = 33'd1 << PAGE_SHIFT;

  // page memory: {exec, dirty, swapped, resident-cleared-by-pass}, frame, slot
  // word: [3:0] flags (resident 0, swapped 1, dirty 2, exec 3), frame, slot
  localparam int MW = 4 + FW + 12;
  logic [MW-1:0] pmem [NUM_PAGES];
  logic [MW-1:0] prd_r;
  logic [PW-1:0] raddr, waddr;
  logic          we;
  logic [MW-1:0] wdata;

  logic [PW-1:0] clr_r;
  logic          clr_busy_r;
  logic          halted_r;
  logic [31:0]   refc_r;
  logic [11:0]   nfree_r;
  logic [PW-1:0] owner_r   [NUM_FRAMES];
  logic [31:0]   age_r     [NUM_FRAMES];
  lpfm_pkg::in_item_t it_r;
  logic [PW-1:0] page_r;
  logic [FW-1:0] best_r;
  logic [FW:0]   idx_r;
  logic          miss_r;    // set once the victim scan has started
  logic [MW-1:0] pg_r;      // new page word, held across owner read
  logic [PW-1:0] own_r;
  lpfm_pkg::out_item_t res_r;

  logic [PW-1:0] in_page;
  logic [19:0]   addr_sh;
  assign addr_sh = in_item.address >> PAGE_SHIFT;
  assign in_page = addr_sh[PW-1:0];

  // exec update applied on view of fetched page word
  logic [MW-1:0] pw;
  always_comb begin
    pw = prd_r;
    if (it_r.command == lpfm_pkg::CMD_READ && it_r.exec_fetch) pw[3] = 1'b1;
  end

  assign sts.halt      = halted_r;
  assign sts.hit       = pw[0];
  assign sts.scan_done = (idx_r == (FW+1)'(NUM_FRAMES - 1));
  assign sts.clr_done  = !clr_busy_r;
  assign res           = res_r;

  // owner word from memory (read in owner state, valid in commit)
  logic [MW-1:0] ow;
  logic          ovict;
  assign ow    = prd_r;
  assign ovict = ow[0] && (ow[4 +: FW] == best_r);

  // load source
  logic [31:0] aligned;
  logic [32:0] diff;
  logic [9:0]  nbytes;
  always_comb begin
    aligned = it_r.img_offset & ~(PSIZE[31:0] - 32'd1);
    diff    = {1'b0, image_size} - {1'b0, aligned};
    if (!it_r.source_is_image) nbytes = PSIZE[9:0];
    else if (image_size <= aligned) nbytes = 10'd0;
    else if (diff > PSIZE) nbytes = PSIZE[9:0];
    else nbytes = diff[9:0];
  end

  logic [11:0] oslot;
  assign oslot = ow[1] ? ow[4+FW +: 12] : nfree_r;

  always_comb begin
    // keep the latched page on the read port once the item is taken
    raddr = cmd.take ? in_page : page_r;
    if (cmd.owner) raddr = owner_r[best_r];
    we = 1'b0; waddr = page_r; wdata = pg_r;
    if (clr_busy_r) begin
      we = 1'b1; waddr = clr_r; wdata = '0;
    end else if (cmd.commit && !halted_r) begin
      if (!miss_r) begin
        we = 1'b1;
        waddr = page_r;
        wdata = pw;
        if (it_r.command == lpfm_pkg::CMD_WRITE) wdata[2] = 1'b1;
      end else if (ovict) begin
        // unmap victim owner; page update follows next cycle via pg_r
        we = 1'b1;
        waddr = own_r;
        wdata = ow;
        wdata[0] = 1'b0;
        if (ow[2]) begin
          wdata[1] = 1'b1;
          wdata[4+FW +: 12] = oslot;
        end
      end
    end else if (res_r.load_kind != lpfm_pkg::LOAD_NONE && pg_r[0]) begin
      // deferred new-page write after a miss
      we = 1'b1; waddr = page_r; wdata = pg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) pmem[waddr] <= wdata;
    prd_r <= pmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0; clr_busy_r <= 1'b1; halted_r <= 1'b0;
      refc_r <= '0; nfree_r <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        owner_r[i] <= PW'(i % NUM_PAGES);
        age_r[i]   <= '0;
      end
      pg_r <= '0;
      res_r.load_kind <= lpfm_pkg::LOAD_NONE;
    end else begin
      if (clr_busy_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == PW'(NUM_PAGES - 1)) clr_busy_r <= 1'b0;
      end
      if (cmd.take) begin
        it_r   <= in_item;
        page_r <= in_page;
        best_r <= '0;
        idx_r  <= '0;
        miss_r <= 1'b0;
        pg_r   <= '0;
        res_r.load_kind <= lpfm_pkg::LOAD_NONE;
        if (in_item.command == lpfm_pkg::CMD_ERROR) halted_r <= 1'b1;
      end
      if (cmd.scan) begin
        miss_r <= 1'b1;
        if (idx_r == '0) pg_r <= pw;  // capture new page word before owner read
        if (!sts.scan_done && age_r[idx_r[FW-1:0] + 1'b1] < age_r[best_r])
          best_r <= idx_r[FW-1:0] + 1'b1;
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.owner) own_r <= owner_r[best_r];
      if (pg_r[0] && !cmd.commit && !cmd.take && !cmd.scan && !cmd.owner)
        pg_r[0] <= 1'b0;  // deferred write done
      if (cmd.commit) begin
        res_r <= '0;
        if (halted_r) begin
          res_r.status <= 1'b1;
        end else if (!miss_r) begin
          res_r.hit   <= 1'b1;
          res_r.frame <= 4'(pw[4 +: FW]);
          if (it_r.command != lpfm_pkg::CMD_SECTOR) begin
            age_r[pw[4 +: FW]] <= refc_r + 32'd1;
            refc_r <= refc_r + 32'd1;
          end
        end else begin
          res_r.frame        <= 4'(best_r);
          res_r.evicted_page <= 11'(own_r);
          if (ovict && ow[2]) begin
            res_r.write_back <= 1'b1;
            res_r.write_slot <= oslot[10:0];
            if (!ow[1]) nfree_r <= nfree_r + 12'd1;
          end
          if (pg_r[1]) begin
            res_r.load_kind <= lpfm_pkg::LOAD_SWAP;
            res_r.load_slot <= pg_r[4+FW +: 11];
          end else if (it_r.has_source) begin
            res_r.load_kind     <= lpfm_pkg::LOAD_SRC;
            res_r.source_offset <= it_r.img_base + aligned;
            res_r.load_bytes    <= nbytes;
          end else begin
            res_r.load_kind <= lpfm_pkg::LOAD_FILL;
          end
          owner_r[best_r] <= page_r;
          age_r[best_r]   <= refc_r + 32'd1;
          refc_r          <= refc_r + 32'd1;
          pg_r[0]         <= 1'b1;
          pg_r[4 +: FW]   <= best_r;
          if (it_r.command == lpfm_pkg::CMD_WRITE) pg_r[2] <= 1'b1;
          // owner same as new page cannot happen: new page is not resident
        end
      end
    end
  end

  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !cmd.take)
    else $error("item taken during clear");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> idx_r < (FW+1)'(NUM_FRAMES))
    else $error("scan overrun");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take, cmd.scan, cmd.owner, cmd.commit}))
    else $error("conflicting commands");
endmodule

// ===== hdl/lru_page_frame_manager.sv =====
// lru_page_frame_manager: top level, controller plus datapath.
// Sequence: a hit or halted item goes from lookup to commit; a miss goes from lookup
// through the age scan and owner read to commit. Throughput: one item at a time.
// Reset: synchronous active-low; a clearing pass over all pages follows reset, and
// the first item is taken after it ends (configuration is taken meanwhile).
// Depends on lpfm_pkg, lpfm_stream_if, lpfm_ctrl, lpfm_dp.
`timescale 1ns / 1ps
module lru_page_frame_manager #(
  parameter int PAGE_SHIFT = 9,
  parameter int NUM_PAGES  = 2048,
  parameter int NUM_FRAMES = 16
) (
  input  logic clk,
  input  logic rst_n,
  lpfm_stream_if.sink   in_ch,
  lpfm_stream_if.source out_ch,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_image_size
);
  lpfm_pkg::dp_cmd_t cmd;
  lpfm_pkg::dp_sts_t sts;
  logic [31:0] image_size_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) image_size_r <= '0;
    else if (cfg_valid) image_size_r <= cfg_image_size;
  end

  lpfm_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  lpfm_dp #(.PAGE_SHIFT(PAGE_SHIFT), .NUM_PAGES(NUM_PAGES), .NUM_FRAMES(NUM_FRAMES)) u_dp (
    .clk, .rst_n, .in_item(in_ch.data), .image_size(image_size_r),
    .cmd, .sts, .res(out_ch.data)
  );
endmodule

// ===== tb/lru_page_frame_manager_test.sv =====
// lru_page_frame_manager_test: self-checking bench for the LRU page frame manager.
// Drives access items and image_size writes, predicts every result, and checks it.
// Depends on lpfm_pkg, lpfm_stream_if and lru_page_frame_manager.
`timescale 1ns / 1ps
module lru_page_frame_manager_test;

  localparam int PSHIFT  = 9;
  localparam int NPAGES  = 2048;
  localparam int NFRAMES = 16;
  localparam logic [3:0] F_RES  = 4'd1;
  localparam logic [3:0] F_SWP  = 4'd2;
  localparam logic [3:0] F_DIRT = 4'd4;
  localparam logic [3:0] F_EXE  = 4'd8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_image_size = '0;

  lpfm_stream_if #(lpfm_pkg::in_item_t)  in_ch ();
  lpfm_stream_if #(lpfm_pkg::out_item_t) out_ch ();

  lru_page_frame_manager dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_image_size(cfg_image_size)
  );

  always #10 clk = ~clk;

  // shadow of the paging tables
  logic [3:0]  pg_flags [NPAGES];
  logic [3:0]  pg_frame [NPAGES];
  logic [11:0] pg_slot  [NPAGES];
  logic [10:0] fr_owner [NFRAMES];
  logic [31:0] fr_age   [NFRAMES];
  logic [31:0] ref_count;
  logic [11:0] free_slot;
  logic        is_halted;
  logic [31:0] img_size;

  lpfm_pkg::out_item_t expected_results[$];
  int  errors = 0;
  bit  quiet = 1'b0;   // no random idling when set

  function automatic void reset_tables();
    for (int i = 0; i < NPAGES; i++) begin
      pg_flags[i] = '0; pg_frame[i] = '0; pg_slot[i] = '0;
    end
    for (int i = 0; i < NFRAMES; i++) begin
      fr_owner[i] = i[10:0]; fr_age[i] = '0;
    end
    ref_count = '0; free_slot = '0; is_halted = 1'b0; img_size = '0;
  endfunction

  function automatic lpfm_pkg::out_item_t page_access(lpfm_pkg::in_item_t it);
    lpfm_pkg::out_item_t r;
    logic [10:0] pg, own;
    logic [3:0]  fr;
    logic [31:0] aligned;
    r = '0;
    if (it.command == lpfm_pkg::CMD_ERROR) is_halted = 1'b1;
    if (is_halted) begin
      r.status = 1'b1;
      return r;
    end
    pg = it.address[19:PSHIFT];
    if (it.command == lpfm_pkg::CMD_READ && it.exec_fetch) pg_flags[pg] |= F_EXE;
    if (pg_flags[pg] & F_RES) begin
      fr = pg_frame[pg];
      if (it.command != lpfm_pkg::CMD_SECTOR) begin
        ref_count++; fr_age[fr] = ref_count;
      end
      r.hit = 1'b1;
    end else begin
      fr = '0;
      for (int i = 1; i < NFRAMES; i++)
        if (fr_age[i] < fr_age[fr]) fr = i[3:0];
      own = fr_owner[fr];
      r.evicted_page = own;
      // stale owners after reset are neither written back nor unmapped
      if ((pg_flags[own] & F_RES) && pg_frame[own] == fr) begin
        if (pg_flags[own] & F_DIRT) begin
          if (!(pg_flags[own] & F_SWP)) begin
            pg_slot[own] = free_slot; free_slot++;
          end
          pg_flags[own] |= F_SWP;
          r.write_back = 1'b1;
          r.write_slot = pg_slot[own][10:0];
        end
        pg_flags[own] &= ~F_RES;
      end
      if (pg_flags[pg] & F_SWP) begin
        r.load_kind = lpfm_pkg::LOAD_SWAP;
        r.load_slot = pg_slot[pg][10:0];
      end else if (it.has_source) begin
        aligned = it.img_offset & ~32'(2 ** PSHIFT - 1);
        r.load_kind = lpfm_pkg::LOAD_SRC;
        r.source_offset = it.img_base + aligned;
        if (!it.source_is_image) r.load_bytes = 10'(2 ** PSHIFT);
        else if (img_size > aligned)
          r.load_bytes = (img_size - aligned > 2 ** PSHIFT) ? 10'(2 ** PSHIFT)
                                                             : 10'(img_size - aligned);
      end else begin
        r.load_kind = lpfm_pkg::LOAD_FILL;
      end
      fr_owner[fr] = pg; pg_frame[pg] = fr; pg_flags[pg] |= F_RES;
      ref_count++; fr_age[fr] = ref_count;
    end
    if (it.command == lpfm_pkg::CMD_WRITE) pg_flags[pg] |= F_DIRT;
    r.frame = fr;
    return r;
  endfunction

  function automatic bit idle_now();
    return !quiet && $urandom_range(99) < 7;
  endfunction

  // valid stays high between back-to-back items; drain drops it
  task automatic send_access(lpfm_pkg::in_item_t it);
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(page_access(it));
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0 && n < 200000) begin
      @(posedge clk); n++;
    end
    repeat (NFRAMES + 10) @(posedge clk);
  endtask

  task automatic write_image_size(logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_image_size <= v;
    do @(posedge clk); while (!cfg_ready);
    img_size = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic lpfm_pkg::in_item_t make_access(logic [1:0] c, logic [19:0] a);
    lpfm_pkg::in_item_t it;
    it.command = c;
    it.address = a;
    it.img_base = $urandom;
    it.img_offset = $urandom;
    it.has_source = 1'($urandom_range(1));
    it.source_is_image = 1'($urandom_range(1));
    it.exec_fetch = 1'($urandom_range(1));
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    lpfm_pkg::out_item_t e, g;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      g = out_ch.data;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, g);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (g !== e) begin
          $display("%0t: result mismatch expected %h actual %h", $time, e, g);
          if (g.frame !== e.frame)
            $display("%0t: frame expected %0d actual %0d", $time, e.frame, g.frame);
          if (g.load_bytes !== e.load_bytes)
            $display("%0t: load_bytes expected %0d actual %0d", $time,
                     e.load_bytes, g.load_bytes);
          errors++;
        end
      end
    end
    out_ch.ready <= !idle_now();
  end

  task automatic test_edges();
    lpfm_pkg::in_item_t it;
    write_image_size(32'd0);
    // small pool of pages forces eviction of dirty pages
    for (int i = 0; i < 20; i++) begin
      it = make_access(i[0] ? lpfm_pkg::CMD_WRITE : lpfm_pkg::CMD_READ,
                       20'((i % 18) << PSHIFT));
      if (i == 0) begin
        it.img_base = 32'hFFFF_FFFF; it.img_offset = 32'hFFFF_FFFF;
        it.has_source = 1'b1; it.source_is_image = 1'b1;
      end
      if (i == 1) it.address = 20'hFFFFF;
      if (i == 2) it.command = lpfm_pkg::CMD_SECTOR;
      send_access(it);
    end
  endtask

  task automatic test_image_lengths();
    lpfm_pkg::in_item_t it;
    logic [31:0] sizes[4] = '{32'hFFFF_FFFF, 32'd700, 32'd100, 32'd1024};
    foreach (sizes[k]) begin
      write_image_size(sizes[k]);
      for (int i = 0; i < 6; i++) begin
        it = make_access(lpfm_pkg::CMD_READ, 20'($urandom_range(NPAGES - 1) << PSHIFT));
        it.has_source = 1'b1; it.source_is_image = 1'b1;
        it.img_offset = $urandom_range(3) ? 32'($urandom_range(2047)) : $urandom;
        send_access(it);
      end
    end
  endtask

  task automatic test_random(int count);
    lpfm_pkg::in_item_t it;
    logic [19:0] a;
    for (int i = 0; i < count; i++) begin
      quiet = (i >= 300 && i < 500);
      if (i == 700) begin
        drain();
        write_image_size($urandom);
      end
      // mostly a working set a little larger than the frame pool
      a = $urandom_range(9) ? 20'($urandom_range(23) << PSHIFT) | 20'($urandom_range(511))
                            : 20'($urandom);
      it = make_access(2'($urandom_range(2)), a);
      if ($urandom_range(1)) it.img_offset = 32'($urandom_range(4095));
      send_access(it);
    end
    quiet = 1'b0;
  endtask

  task automatic test_halt();
    lpfm_pkg::in_item_t it;
    for (int i = 0; i < 12; i++) begin
      it = make_access(2'($urandom_range(3)), 20'($urandom));
      if (i == 2) it.command = lpfm_pkg::CMD_ERROR;
      send_access(it);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    reset_tables();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_edges();
    test_image_lengths();
    test_random(1500);
    test_halt();
    drain();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(200_000_000);
    $display("Mismatches found");
    $finish;
  end
endmodule
